/* rtl/core/tmp_pkg.sv */
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types, constants and saturating helpers for the trapezoidal
// motion profile generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tmp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int VAL_BITS  = WORD_BITS - 1;

	typedef logic [VAL_BITS-1:0] val_t;

	localparam val_t SAT_MAX = {VAL_BITS{1'b1}};

	// configuration register indexes
	localparam logic [3:0] REG_CRUISE_VEL = 4'd0;
	localparam logic [3:0] REG_ACCEL      = 4'd1;
	localparam logic [3:0] REG_INIT_VEL   = 4'd2;
	localparam logic [3:0] REG_PATH_LEN   = 4'd3;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_UP     = 3'd1,
		PH_CRUISE = 3'd2,
		PH_DOWN   = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [4:0] {
		ST_START,
		ST_LA,
		ST_VV,
		ST_VEL2,
		ST_A_ET,
		ST_A_EA,
		ST_SQ_MUL,
		ST_SQ_CMP,
		ST_B_START,
		ST_B_RUT,
		ST_B_ET,
		ST_RP1,
		ST_RP2,
		ST_RP3,
		ST_RP4,
		ST_C_RUT,
		ST_C_SD,
		ST_C_RD,
		ST_C_ET,
		ST_DONE
	} plan_state_t;

	// working configuration (velocity and acceleration already forced >= 1 LSB)
	typedef struct packed {
		val_t vel;
		val_t acc;
		val_t v0;
		val_t len;
	} cfg_t;

	// planned phase boundaries
	typedef struct packed {
		logic valid;
		val_t rut;
		val_t rupos;
		val_t rdst;
		val_t et;
		val_t ea;
	} plan_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [31:0] den;
	} div_req_t;

	function automatic val_t sat_w(input logic [63:0] x);
		return (x > 64'(SAT_MAX)) ? SAT_MAX : x[VAL_BITS-1:0];
	endfunction

	function automatic val_t sadd(input val_t a, input val_t b);
		logic [VAL_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[VAL_BITS] ? SAT_MAX : s[VAL_BITS-1:0];
	endfunction

	function automatic val_t ssub(input val_t a, input val_t b);
		return (a > b) ? val_t'(a - b) : '0;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/tmp_div.sv */
// ----------------------------------------------------------------------------
// tmp_div
// Restoring divider, one quotient bit per cycle over a 64-bit numerator.
// Quotient saturates at SAT_MAX; a zero divisor also gives SAT_MAX.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tmp_pkg::div_req_t req,
	output logic                  done,
	output tmp_pkg::val_t         quo
);
	import tmp_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] num_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;

	logic [32:0] rem_sh;
	logic        ge;
	logic [32:0] rem_nx;

	// one compare and subtract step
	always_comb begin
		rem_sh = {rem_q, num_q[63]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			rem_q <= rem_nx[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = (quo_q[63:VAL_BITS] != '0) ? SAT_MAX : quo_q[VAL_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/core/tmp_plan.sv */
// ----------------------------------------------------------------------------
// tmp_plan
// Profile planner: picks stop-only, triangle or plateau case and computes
// the phase boundaries with one shared multiplier, a bitwise square root
// on that multiplier and a serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_plan (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          restart,
	input  wire tmp_pkg::cfg_t cfg,
	output tmp_pkg::plan_t     plan
);
	import tmp_pkg::*;

	plan_state_t state_q, state_nx;

	logic [61:0] prod_q;
	logic [63:0] two_la_q;
	logic [63:0] vv_q;
	logic [61:0] vel2_q;
	logic [63:0] rad_q;
	val_t        root_q;
	logic [4:0]  idx_q;
	logic        case_c_q;
	val_t        tmp_q;
	val_t        vt_q;
	val_t        rut_q;
	val_t        rupos_q;
	val_t        rdst_q;
	val_t        et_q;
	val_t        ea_q;

	val_t        mul_a;
	val_t        mul_b;
	div_req_t    div_req;
	logic        div_done;
	val_t        div_quo;

	logic [63:0] lhs;
	logic        case_a;
	logic        case_b;
	val_t        dv;
	val_t        cand;
	val_t        half_t2;
	val_t        rp_pos;

	tmp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	// case selection and small helpers
	always_comb begin
		lhs     = two_la_q + vv_q;
		case_a  = two_la_q < vv_q;
		case_b  = !case_a && (lhs < {1'b0, prod_q, 1'b0});
		dv      = (cfg.vel > cfg.v0) ? val_t'(cfg.vel - cfg.v0) : val_t'(cfg.v0 - cfg.vel);
		cand    = root_q | (val_t'(1) << idx_q);
		half_t2 = sat_w({2'b0, prod_q} >> (FRAC_BITS + 1));
		rp_pos  = (cfg.v0 < cfg.vel) ? sadd(vt_q, half_t2) : ssub(vt_q, half_t2);
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_START:   state_nx = ST_LA;
			ST_LA:      state_nx = ST_VV;
			ST_VV:      state_nx = ST_VEL2;
			ST_VEL2: begin
				if (case_a)
					state_nx = ST_A_ET;
				else if (case_b)
					state_nx = ST_SQ_MUL;
				else
					state_nx = ST_C_RUT;
			end
			ST_A_ET:    if (div_done) state_nx = ST_A_EA;
			ST_A_EA:    if (div_done) state_nx = ST_DONE;
			ST_SQ_MUL:  state_nx = ST_SQ_CMP;
			ST_SQ_CMP:  state_nx = (idx_q == 5'd0) ? ST_B_START : ST_SQ_MUL;
			ST_B_START: state_nx = ST_B_RUT;
			ST_B_RUT:   if (div_done) state_nx = ST_B_ET;
			ST_B_ET:    if (div_done) state_nx = ST_RP1;
			ST_RP1:     state_nx = ST_RP2;
			ST_RP2:     state_nx = ST_RP3;
			ST_RP3:     state_nx = ST_RP4;
			ST_RP4:     state_nx = case_c_q ? ST_C_SD : ST_DONE;
			ST_C_RUT:   if (div_done) state_nx = ST_RP1;
			ST_C_SD:    if (div_done) state_nx = ST_C_RD;
			ST_C_RD:    if (div_done) state_nx = ST_C_ET;
			ST_C_ET:    if (div_done) state_nx = ST_DONE;
			ST_DONE:    state_nx = ST_DONE;
			default:    state_nx = ST_START;
		endcase
	end

	// multiplier operands and divider requests
	always_comb begin
		mul_a         = '0;
		mul_b         = '0;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		case (state_q)
			ST_START: begin
				mul_a = cfg.len;
				mul_b = cfg.acc;
			end
			ST_LA: begin
				mul_a = cfg.v0;
				mul_b = cfg.v0;
			end
			ST_VV: begin
				mul_a = cfg.vel;
				mul_b = cfg.vel;
			end
			ST_VEL2: begin
				if (case_a) begin
					div_req.start = 1'b1;
					div_req.num   = 64'(cfg.len) << (FRAC_BITS + 1);
					div_req.den   = 32'(cfg.v0);
				end else if (!case_b) begin
					div_req.start = 1'b1;
					div_req.num   = 64'(dv) << FRAC_BITS;
					div_req.den   = 32'(cfg.acc);
				end
			end
			ST_A_ET: begin
				if (div_done) begin
					div_req.start = 1'b1;
					div_req.num   = vv_q;
					div_req.den   = {cfg.len, 1'b0};
				end
			end
			ST_SQ_MUL: begin
				mul_a = cand;
				mul_b = cand;
			end
			ST_B_START: begin
				div_req.start = 1'b1;
				div_req.num   = 64'(ssub(root_q, cfg.v0)) << FRAC_BITS;
				div_req.den   = 32'(cfg.acc);
			end
			ST_B_RUT: begin
				if (div_done) begin
					div_req.start = 1'b1;
					div_req.num   = 64'(root_q) << FRAC_BITS;
					div_req.den   = 32'(cfg.acc);
				end
			end
			ST_RP1: begin
				mul_a = cfg.v0;
				mul_b = rut_q;
			end
			ST_RP2: begin
				mul_a = ea_q;
				mul_b = rut_q;
			end
			ST_RP3: begin
				mul_a = sat_w({2'b0, prod_q} >> FRAC_BITS);
				mul_b = rut_q;
			end
			ST_RP4: begin
				if (case_c_q) begin
					div_req.start = 1'b1;
					div_req.num   = {2'b0, vel2_q};
					div_req.den   = {cfg.acc, 1'b0};
				end
			end
			ST_C_SD: begin
				if (div_done) begin
					div_req.start = 1'b1;
					div_req.num   = 64'(ssub(ssub(cfg.len, div_quo), rupos_q)) << FRAC_BITS;
					div_req.den   = 32'(cfg.vel);
				end
			end
			ST_C_RD: begin
				if (div_done) begin
					div_req.start = 1'b1;
					div_req.num   = 64'(cfg.vel) << FRAC_BITS;
					div_req.den   = 32'(cfg.acc);
				end
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
		end else if (restart) begin
			state_q <= ST_START;
		end else begin
			state_q <= state_nx;
		end
	end

	// plan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rut_q   <= '0;
			rupos_q <= '0;
			rdst_q  <= '0;
			et_q    <= '0;
			ea_q    <= '0;
		end else begin
			case (state_q)
				ST_VEL2: ea_q <= cfg.acc;
				ST_A_ET: if (div_done) et_q <= div_quo;
				ST_A_EA: begin
					if (div_done) begin
						ea_q    <= div_quo;
						rut_q   <= '0;
						rupos_q <= '0;
						rdst_q  <= '0;
					end
				end
				ST_B_RUT: if (div_done) rut_q <= div_quo;
				ST_RP4: begin
					rupos_q <= rp_pos;
					if (!case_c_q) begin
						rdst_q <= rut_q;
						et_q   <= sadd(rut_q, tmp_q);
					end
				end
				ST_C_RUT: if (div_done) rut_q <= div_quo;
				ST_C_RD:  if (div_done) rdst_q <= sadd(rut_q, div_quo);
				ST_C_ET:  if (div_done) et_q <= sadd(rdst_q, div_quo);
				default: begin
					ea_q <= ea_q;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LA: two_la_q <= {1'b0, prod_q, 1'b0};
			ST_VV: vv_q <= {2'b0, prod_q};
			ST_VEL2: begin
				vel2_q   <= prod_q;
				case_c_q <= !case_a && !case_b;
				rad_q    <= lhs >> 1;
				root_q   <= '0;
				idx_q    <= 5'(VAL_BITS - 1);
			end
			ST_SQ_CMP: begin
				if (!(rad_q < {2'b0, prod_q}))
					root_q <= cand;
				idx_q <= idx_q - 5'd1;
			end
			ST_B_ET: if (div_done) tmp_q <= div_quo;
			ST_RP2:  vt_q <= sat_w({2'b0, prod_q} >> FRAC_BITS);
			default: begin
				tmp_q <= tmp_q;
			end
		endcase
	end

	always_comb begin
		plan.valid = (state_q == ST_DONE);
		plan.rut   = rut_q;
		plan.rupos = rupos_q;
		plan.rdst  = rdst_q;
		plan.et    = et_q;
		plan.ea    = ea_q;
	end

endmodule

`default_nettype wire

/* rtl/core/trapezoidal_motion_profile.sv */
// An accepted time word passes through the stage 1, 2, 3 and 4 registers to its result word.
// Throughput: one word per cycle once planned, while out_ready holds no stage back;
// the four-stage sample pipeline with its two multiplier stages sets this.
// Planning after reset or a configuration write runs the serial divider and,
// for a triangle, the square root loop; in_ready stays low until the plan is valid.
// Reset is asynchronous, active low; it loads default registers and replans.
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile
// Trapezoidal velocity profile generator: plans the phase boundaries from the
// configuration, then maps each sample time to position, phase and end time.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoidal_motion_profile (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [3:0]  wr_index,
	input  wire logic [30:0] wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] time_now,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [30:0]      position,
	output logic [2:0]       phase,
	output logic             finished,
	output logic [30:0]      total_time
);
	import tmp_pkg::*;

	val_t   vel_q, acc_q, v0_q, len_q;
	cfg_t   cfg;
	plan_t  plan;
	logic   restart;

	// stage valids and enables
	logic   v_s1, v_s2, v_s3, v_s4;
	logic   en1, en2, en3, en4;

	phase_t ph_in;
	val_t   dt_in;
	val_t   ma_in;
	val_t   t_in;

	phase_t      phase_s1, phase_s2, phase_s3, phase_s4;
	val_t        dt_s1, dt_s2;
	val_t        ma_s1;
	logic [61:0] p1_s2, p0_s2;
	val_t        x_s3, vt_s3;
	logic [61:0] p2_s3;
	val_t        pos_s4;
	val_t        et_s4;
	val_t        h_s3;
	val_t        pos_nx;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q <= val_t'(1) << FRAC_BITS;
			acc_q <= val_t'(1) << FRAC_BITS;
			v0_q  <= '0;
			len_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CRUISE_VEL: vel_q <= wr_data;
				REG_ACCEL:      acc_q <= wr_data;
				REG_INIT_VEL:   v0_q  <= wr_data;
				REG_PATH_LEN:   len_q <= wr_data;
				default:        vel_q <= vel_q;
			endcase
		end
	end

	assign restart = wr_en && (wr_index <= REG_PATH_LEN);

	always_comb begin
		cfg.vel = (vel_q == '0) ? val_t'(1) : vel_q;
		cfg.acc = (acc_q == '0) ? val_t'(1) : acc_q;
		cfg.v0  = v0_q;
		cfg.len = len_q;
	end

	tmp_plan u_plan (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.cfg     (cfg),
		.plan    (plan)
	);

	// per-stage enables: a stage loads when empty or when it moves on
	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1 && plan.valid;

	// phase decode and ramp operand select
	always_comb begin
		t_in  = time_now[30:0];
		dt_in = '0;
		ma_in = plan.ea;
		if (time_now[31]) begin
			ph_in = PH_IDLE;
		end else if (t_in < plan.rut) begin
			ph_in = PH_UP;
			dt_in = t_in;
		end else if (t_in < plan.rdst) begin
			ph_in = PH_CRUISE;
			dt_in = val_t'(t_in - plan.rut);
			ma_in = cfg.vel;
		end else if (t_in < plan.et) begin
			ph_in = PH_DOWN;
			dt_in = val_t'(plan.et - t_in);
		end else begin
			ph_in = PH_DONE;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid && in_ready;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: decoded phase and operands
	always_ff @(posedge clk) begin
		if (en1) begin
			phase_s1 <= ph_in;
			dt_s1    <= dt_in;
			ma_s1    <= ma_in;
		end
	end

	// stage 2: first products
	always_ff @(posedge clk) begin
		if (en2) begin
			phase_s2 <= phase_s1;
			dt_s2    <= dt_s1;
			p1_s2    <= ma_s1 * dt_s1;
			p0_s2    <= cfg.v0 * dt_s1;
		end
	end

	// stage 3: scale, then a*t*t
	always_ff @(posedge clk) begin
		if (en3) begin
			phase_s3 <= phase_s2;
			x_s3     <= sat_w({2'b0, p1_s2} >> FRAC_BITS);
			vt_s3    <= sat_w({2'b0, p0_s2} >> FRAC_BITS);
			p2_s3    <= sat_w({2'b0, p1_s2} >> FRAC_BITS) * dt_s2;
		end
	end

	// stage 4: combine per phase
	always_comb begin
		h_s3 = sat_w({2'b0, p2_s3} >> (FRAC_BITS + 1));
		case (phase_s3)
			PH_IDLE:   pos_nx = '0;
			PH_UP:     pos_nx = (cfg.v0 < cfg.vel) ? sadd(vt_s3, h_s3) : ssub(vt_s3, h_s3);
			PH_CRUISE: pos_nx = sadd(plan.rupos, x_s3);
			PH_DOWN:   pos_nx = ssub(cfg.len, h_s3);
			PH_DONE:   pos_nx = cfg.len;
			default:   pos_nx = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			phase_s4 <= phase_s3;
			pos_s4   <= pos_nx;
			et_s4    <= plan.et;
		end
	end

	assign out_valid  = v_s4;
	assign position   = pos_s4;
	assign phase      = phase_s4;
	assign finished   = (phase_s4 == PH_DONE);
	assign total_time = et_s4;

endmodule

`default_nettype wire

/* dv/trapezoidal_motion_profile_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile_test
// Self-checking bench for the trapezoidal motion profile generator. A queue of
// time words and register writes feeds a clocked driver. Each accepted time
// word is run through a bit-exact profile planner and sampler kept in the
// bench. A clocked monitor checks every result word against the oldest
// prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoidal_motion_profile_test;
	import tmp_pkg::*;

	typedef logic [63:0] u64_t;
	typedef logic [127:0] u128_t;

	localparam u64_t SATV   = 64'(SAT_MAX);
	localparam u64_t ONE_Q  = 64'd1 << FRAC_BITS;
	localparam int   CALM_LO = 300;
	localparam int   CALM_HI = 450;

	typedef enum logic [1:0] {OP_WORD, OP_WRITE, OP_DRAIN} op_kind_t;

	typedef struct {
		op_kind_t    kind;
		logic [3:0]  idx;
		logic [30:0] data;
		logic [31:0] t;
	} op_t;

	typedef struct {
		logic [30:0] position;
		phase_t      phase;
		logic        finished;
		logic [30:0] total_time;
	} sample_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [3:0]  wr_index = '0;
	logic [30:0] wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] time_now = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [30:0] position;
	logic [2:0]  phase;
	logic        finished;
	logic [30:0] total_time;

	op_t     pending_ops[$];
	sample_t expected_samples[$];
	int      fail_count = 0;
	int      sent_count = 0;
	int      recv_count = 0;
	int      quiet_cycles = 0;

	// bench copy of registers and plan
	u64_t reg_val[4];
	logic plan_ok;
	u64_t rup_time, rup_pos, rdown_time, stop_time, stop_pos, eff_acc;

	trapezoidal_motion_profile u_dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .time_now(time_now),
		.out_valid(out_valid), .out_ready(out_ready),
		.position(position), .phase(phase), .finished(finished),
		.total_time(total_time)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------- fixed-point helpers ----------------
	function automatic u64_t quot_sat(input u128_t n, input u64_t d);
		u128_t q;
		if (d == 0) return SATV;
		q = n / {64'd0, d};
		return (q > {64'd0, SATV}) ? SATV : q[63:0];
	endfunction

	function automatic u64_t scaled_quot(input u64_t a, input u64_t b, input u64_t d);
		return quot_sat({64'd0, a} * {64'd0, b}, d);
	endfunction

	function automatic u64_t sat_add(input u64_t a, input u64_t b);
		u64_t s;
		s = a + b;
		return (s > SATV) ? SATV : s;
	endfunction

	function automatic u64_t floor_sub(input u64_t a, input u64_t b);
		return (a > b) ? a - b : 64'd0;
	endfunction

	function automatic u64_t half_acc_sq(input u64_t a, input u64_t t);
		return scaled_quot(scaled_quot(a, t, ONE_Q), t, 2 * ONE_Q);
	endfunction

	function automatic u64_t floor_root(input u128_t r);
		u64_t y, c;
		y = 0;
		for (int i = WORD_BITS - 2; i >= 0; i--) begin
			c = y | (64'd1 << i);
			if (!(r < ({64'd0, c} * {64'd0, c}))) y = c;
		end
		return y;
	endfunction

	function automatic u64_t cruise_v();
		return (reg_val[REG_CRUISE_VEL] == 0) ? 64'd1 : reg_val[REG_CRUISE_VEL];
	endfunction

	// distance on the first ramp, up or down toward cruise
	function automatic u64_t ramp_dist(input u64_t t);
		u64_t v0, vt, h;
		v0 = reg_val[REG_INIT_VEL];
		vt = scaled_quot(v0, t, ONE_Q);
		h  = half_acc_sq(eff_acc, t);
		return (v0 < cruise_v()) ? sat_add(vt, h) : floor_sub(vt, h);
	endfunction

	// phase boundaries from the current registers
	task automatic plan_profile();
		u64_t vel, acc, v0, len, vtop, dv, sd;
		u128_t two_la, vv, lhs;
		vel = cruise_v();
		acc = (reg_val[REG_ACCEL] == 0) ? 64'd1 : reg_val[REG_ACCEL];
		v0  = reg_val[REG_INIT_VEL];
		len = reg_val[REG_PATH_LEN];
		two_la = {64'd0, len} * {64'd0, 2 * acc};
		vv     = {64'd0, v0} * {64'd0, v0};
		stop_pos = len;
		eff_acc  = acc;
		if (two_la < vv) begin
			// too short to brake at the set rate
			rup_time   = 0;
			rup_pos    = 0;
			rdown_time = 0;
			stop_time  = scaled_quot(2 * len, ONE_Q, v0);
			eff_acc    = scaled_quot(v0, v0, 2 * len);
		end else begin
			lhs = two_la + vv;
			if (lhs < ({64'd0, 2 * vel} * {64'd0, vel})) begin
				// triangle, no plateau
				vtop       = floor_root(lhs >> 1);
				rup_time   = scaled_quot(floor_sub(vtop, v0), ONE_Q, acc);
				rup_pos    = ramp_dist(rup_time);
				rdown_time = rup_time;
				stop_time  = sat_add(rup_time, scaled_quot(vtop, ONE_Q, acc));
			end else begin
				dv         = (vel > v0) ? vel - v0 : v0 - vel;
				rup_time   = scaled_quot(dv, ONE_Q, acc);
				rup_pos    = ramp_dist(rup_time);
				sd         = floor_sub(len, scaled_quot(vel, vel, 2 * acc));
				rdown_time = sat_add(rup_time,
					scaled_quot(floor_sub(sd, rup_pos), ONE_Q, vel));
				stop_time  = sat_add(rdown_time, scaled_quot(vel, ONE_Q, acc));
			end
		end
		plan_ok = 1'b1;
	endtask

	task automatic predict_sample(input logic [31:0] t);
		sample_t s;
		u64_t tt, pos;
		if (!plan_ok) plan_profile();
		tt = {32'd0, t};
		s.finished = 1'b0;
		if (t[31]) begin
			pos = 0;
			s.phase = PH_IDLE;
		end else if (tt < rup_time) begin
			pos = ramp_dist(tt);
			s.phase = PH_UP;
		end else if (tt < rdown_time) begin
			pos = sat_add(rup_pos, scaled_quot(cruise_v(), tt - rup_time, ONE_Q));
			s.phase = PH_CRUISE;
		end else if (tt < stop_time) begin
			pos = floor_sub(stop_pos, half_acc_sq(eff_acc, stop_time - tt));
			s.phase = PH_DOWN;
		end else begin
			pos = stop_pos;
			s.phase = PH_DONE;
			s.finished = 1'b1;
		end
		s.position   = (pos > SATV) ? SAT_MAX : pos[30:0];
		s.total_time = (stop_time > SATV) ? SAT_MAX : stop_time[30:0];
		expected_samples.push_back(s);
	endtask

	task automatic apply_write(input logic [3:0] idx, input logic [30:0] data);
		if (idx <= REG_PATH_LEN) begin
			reg_val[idx] = {33'd0, data};
			plan_ok = 1'b0;
		end
	endtask

	// ---------------- stimulus building ----------------
	task automatic add_word(input logic [31:0] t);
		op_t o;
		o.kind = OP_WORD; o.idx = '0; o.data = '0; o.t = t;
		pending_ops.push_back(o);
	endtask

	task automatic add_write(input logic [3:0] idx, input logic [30:0] data);
		op_t o;
		o.kind = OP_WRITE; o.idx = idx; o.data = data; o.t = '0;
		pending_ops.push_back(o);
	endtask

	task automatic add_drain();
		op_t o;
		o.kind = OP_DRAIN; o.idx = '0; o.data = '0; o.t = '0;
		pending_ops.push_back(o);
	endtask

	task automatic add_profile(input logic [30:0] vel, input logic [30:0] acc,
			input logic [30:0] v0, input logic [30:0] len);
		add_write(REG_CRUISE_VEL, vel);
		add_write(REG_ACCEL, acc);
		add_write(REG_INIT_VEL, v0);
		add_write(REG_PATH_LEN, len);
	endtask

	// random register value, mostly of modest size
	function automatic logic [30:0] rand_reg();
		return 31'($urandom >> $urandom_range(1, 31));
	endfunction

	function automatic logic [31:0] rand_time();
		if ($urandom_range(0, 9) == 0) return $urandom | 32'h8000_0000;
		return $urandom >> $urandom_range(1, 31);
	endfunction

	// ---------------- driver ----------------
	always @(posedge clk) begin : drive_words
		logic     vld_n, wen_n;
		logic [31:0] t_n;
		logic [3:0]  idx_n;
		logic [30:0] dat_n;
		logic     calm;
		op_t      o;
		vld_n = in_valid;
		t_n   = time_now;
		wen_n = 1'b0;
		idx_n = wr_index;
		dat_n = wr_data;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_sample(time_now);
				sent_count++;
				vld_n = 1'b0;
			end
			if (expected_samples.size() != 0 || in_valid) quiet_cycles = 8;
			else if (quiet_cycles > 0) quiet_cycles--;
			calm = (sent_count >= CALM_LO) && (sent_count < CALM_HI);
			if (!vld_n && pending_ops.size() != 0) begin
				o = pending_ops[0];
				if (o.kind == OP_WORD) begin
					if (calm || $urandom_range(0, 99) >= 23) begin
						vld_n = 1'b1;
						t_n = o.t;
						void'(pending_ops.pop_front());
					end
				end else if (quiet_cycles == 0 && !in_valid) begin
					// block is idle: write a register or end a pause
					if (o.kind == OP_WRITE) begin
						wen_n = 1'b1;
						idx_n = o.idx;
						dat_n = o.data;
						apply_write(o.idx, o.data);
					end
					void'(pending_ops.pop_front());
				end
			end
		end
		in_valid <= vld_n;
		time_now <= t_n;
		wr_en    <= wen_n;
		wr_index <= idx_n;
		wr_data  <= dat_n;
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin : check_words
		sample_t e;
		logic    calm;
		if (arst_n && out_valid && out_ready) begin
			recv_count++;
			if (expected_samples.size() == 0) begin
				$error("result word with no prediction pending");
				fail_count++;
			end else begin
				e = expected_samples.pop_front();
				if (position !== e.position) begin
					$error("position: expected %0d, got %0d", e.position, position);
					fail_count++;
				end
				if (phase !== e.phase) begin
					$error("phase: expected %0d, got %0d", e.phase, phase);
					fail_count++;
				end
				if (finished !== e.finished) begin
					$error("finished: expected %0d, got %0d", e.finished, finished);
					fail_count++;
				end
				if (total_time !== e.total_time) begin
					$error("total_time: expected %0d, got %0d", e.total_time, total_time);
					fail_count++;
				end
			end
		end
		calm = (recv_count >= CALM_LO) && (recv_count < CALM_HI);
		out_ready <= arst_n && (calm || $urandom_range(0, 99) >= 23);
	end

	// ---------------- sequence ----------------
	initial begin : run_test
		int n;
		reg_val[REG_CRUISE_VEL] = ONE_Q;
		reg_val[REG_ACCEL]      = ONE_Q;
		reg_val[REG_INIT_VEL]   = 0;
		reg_val[REG_PATH_LEN]   = 0;
		plan_ok = 1'b0;
		rup_time = 0; rup_pos = 0; rdown_time = 0;
		stop_time = 0; stop_pos = 0; eff_acc = 0;

		// reset defaults: zero path, negative and extreme times
		add_word(32'hFFFF_FFFF);
		add_word(32'h8000_0000);
		add_word(32'h0000_0000);
		add_word(32'h7FFF_FFFF);
		// plateau, ramping up from rest
		add_profile(31'h2_0000, 31'h1_0000, 31'd0, 31'hA_0000);
		add_word(32'h0000_8000);
		add_word(32'h0003_0000);
		add_word(32'h0005_8000);
		add_word(32'h0007_0000);
		// plateau, ramping down from a fast start
		add_profile(31'h1_0000, 31'h1_0000, 31'h2_0000, 31'h40_0000);
		add_word(32'h0000_8000);
		add_word(32'h0010_0000);
		add_word(32'h0040_5000);
		// triangle with no plateau
		add_profile(31'h7FFF_FFFF, 31'h2_0000, 31'h0_8000, 31'h3_0000);
		add_word(32'h0000_C000);
		add_word(32'h0002_0000);
		// stop only, and zero-length stop
		add_profile(31'h1_0000, 31'h1_0000, 31'h8_0000, 31'h1_0000);
		add_word(32'h0000_2000);
		add_write(REG_PATH_LEN, 31'd0);
		add_word(32'h0000_0000);
		// zero velocity and acceleration, then an ignored register index
		add_profile(31'd0, 31'd0, 31'd0, 31'h7FFF_FFFF);
		add_word(32'h7FFF_FFFF);
		add_write(4'(REG_PATH_LEN + 1 + $urandom_range(0, 11)), 31'h5555_5555);
		add_word(32'h1234_5678);
		// everything at the top of its range
		add_profile(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		add_word(32'h0000_0001);

		// random profiles with random sample times
		for (int p = 0; p < 12; p++) begin
			add_profile(rand_reg(), rand_reg(), ($urandom_range(0, 2) == 0) ? 31'd0 :
				rand_reg(), rand_reg());
			if ($urandom_range(0, 4) == 0)
				add_write(4'($urandom_range(4, 15)), 31'($urandom));
			n = $urandom_range(40, 80);
			for (int i = 0; i < n; i++) begin
				if (i == n / 2 && p % 4 == 1) add_drain();
				add_word(rand_time());
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_ops.size() == 0 && !in_valid);
		wait (expected_samples.size() == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("trapezoidal_motion_profile_test OK");
		else
			$display("trapezoidal_motion_profile_test NOT OK");
		$finish;
	end

	initial begin : watchdog
		#10ms;
		$display("trapezoidal_motion_profile_test NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
